### src/tpd_pkg.sv
// Shared types and constants for the two-channel touch press detector.
// No dependencies; imported by every module under src.
package tpd_pkg;

  localparam logic [1:0] OP_CAPTURE = 2'd0;
  localparam logic [1:0] OP_START   = 2'd1;
  localparam logic [1:0] OP_FINISH  = 2'd2;

  localparam logic [15:0] THRESHOLD_RESET = 16'd28;
  localparam logic [15:0] COUNT_MAX       = 16'hffff;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] capture_time;
  } in_item_t;

  typedef struct packed {
    logic        sensor;
    logic [15:0] press_length;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic [1:0]  operation;
    logic        ch;
    logic [15:0] period;
  } cmd_t;

  // Queue write side
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_wr_t;

  // Queue read side status
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_rd_t;

endpackage

### src/tpd_front.sv
// Front end: accepts input items, tracks channel and previous capture,
// computes the period and classifies the item. Depends on tpd_pkg.
module tpd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  tpd_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              in_stall,
  output tpd_pkg::cmd_wr_t  q_wr
);
  import tpd_pkg::*;

  logic        active_channel_r, active_channel_nxt;
  logic [15:0] prev_capture_r, prev_capture_nxt;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  always_comb begin
    active_channel_nxt = active_channel_r;
    prev_capture_nxt   = prev_capture_r;
    q_wr.valid         = 1'b0;
    q_wr.cmd.operation = in_data.operation;
    q_wr.cmd.ch        = ~active_channel_r;
    q_wr.cmd.period    = in_data.capture_time - prev_capture_r;
    if (accept) begin
      case (in_data.operation)
        OP_CAPTURE: begin
          active_channel_nxt = ~active_channel_r;
          prev_capture_nxt   = in_data.capture_time;
          q_wr.valid         = 1'b1;
        end
        OP_START: begin
          active_channel_nxt = 1'b0;
          q_wr.valid         = 1'b1;
        end
        OP_FINISH: begin
          q_wr.valid = 1'b1;
        end
        default: begin
          // unused code: dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_channel_r <= 1'b0;
      prev_capture_r   <= 16'd0;
    end else begin
      active_channel_r <= active_channel_nxt;
      prev_capture_r   <= prev_capture_nxt;
    end
  end

endmodule

### src/tpd_queue.sv
// Short command queue between front and back ends.
// Depends on tpd_pkg for cmd_t and the depth constants.
module tpd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  tpd_pkg::cmd_wr_t wr,
  input  logic             rd_pop,
  output tpd_pkg::cmd_rd_t rd,
  output logic             full
);
  import tpd_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign rd.valid = (count_r != '0);
  assign rd.cmd   = slot_r[rd_ptr_r];
  assign push     = wr.valid & ~full;
  assign pop      = rd_pop & rd.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### src/tpd_back.sv
// Back end: baselines, press counters, calibration flag, threshold
// register and the result register. Depends on tpd_pkg.
module tpd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tpd_pkg::cmd_rd_t   q_rd,
  output logic               q_pop,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tpd_pkg::out_item_t out_data
);
  import tpd_pkg::*;

  logic [15:0] threshold_r, threshold_nxt;
  logic [15:0] baseline_r [2];
  logic [15:0] baseline_nxt [2];
  logic [15:0] count_r [2];
  logic [15:0] count_nxt [2];
  logic        calib_r, calib_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;
  logic        ch;
  logic [15:0] cur_base, cur_count;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Pop whenever the result register is free or being drained
  assign q_pop     = q_rd.valid & (~out_valid_r | ~out_stall);
  assign ch        = q_rd.cmd.ch;
  assign cur_base  = baseline_r[ch];
  assign cur_count = count_r[ch];

  always_comb begin
    threshold_nxt   = (cfg_valid) ? cfg_data : threshold_r;
    baseline_nxt[0] = baseline_r[0];
    baseline_nxt[1] = baseline_r[1];
    count_nxt[0]    = count_r[0];
    count_nxt[1]    = count_r[1];
    calib_nxt       = calib_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r & out_stall;
    if (q_pop) begin
      case (q_rd.cmd.operation)
        OP_CAPTURE: begin
          if (q_rd.cmd.period < cur_base) begin
            if (calib_r) begin
              baseline_nxt[ch] = q_rd.cmd.period;
            end else if (cur_count != COUNT_MAX) begin
              count_nxt[ch] = cur_count + 16'd1;
            end
          end else begin
            out_valid_nxt             = 1'b1;
            out_data_nxt.sensor       = ch;
            out_data_nxt.press_length = cur_count;
            count_nxt[ch]             = 16'd0;
          end
        end
        OP_START: begin
          baseline_nxt[0] = COUNT_MAX;
          baseline_nxt[1] = COUNT_MAX;
          calib_nxt       = 1'b1;
        end
        OP_FINISH: begin
          baseline_nxt[0] = baseline_r[0] - threshold_r;
          baseline_nxt[1] = baseline_r[1] - threshold_r;
          calib_nxt       = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= THRESHOLD_RESET;
      baseline_r[0] <= COUNT_MAX;
      baseline_r[1] <= COUNT_MAX;
      count_r[0]    <= 16'd0;
      count_r[1]    <= 16'd0;
      calib_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      threshold_r   <= threshold_nxt;
      baseline_r[0] <= baseline_nxt[0];
      baseline_r[1] <= baseline_nxt[1];
      count_r[0]    <= count_nxt[0];
      count_r[1]    <= count_nxt[1];
      calib_r       <= calib_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

endmodule

### src/two_channel_touch_press_detector_top.sv
// Two-channel touch press detector, top level.
// A result passes through the command queue and then the result register after its capture is accepted.
// Throughput: one item per cycle; the input stalls only while the two-entry
// queue is full, which happens once a waiting result blocks the queue and it fills up.
// Reset (rst_n, synchronous, active low): channel 0, previous capture 0,
// baselines 0xffff, press counts 0, calibration off, threshold 28.
module two_channel_touch_press_detector_top (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  tpd_pkg::in_item_t  in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output tpd_pkg::out_item_t out_data,
  // threshold write port
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import tpd_pkg::*;

  cmd_wr_t q_wr;
  cmd_rd_t q_rd;
  logic    q_full;
  logic    q_pop;

  // Front: flips the channel, takes the period since the last capture,
  // and drops unused operation codes before they reach the queue.
  tpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .in_stall (in_stall),
    .q_wr     (q_wr)
  );

  // Queue decouples front from back so each can stall on its own.
  tpd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .rd_pop (q_pop),
    .rd     (q_rd),
    .full   (q_full)
  );

  // Back: compares period against baseline, calibrates or counts,
  // and issues release transfers from a registered output.
  tpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rd      (q_rd),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### tb/two_channel_touch_press_detector_top_tb.sv
// Self-checking bench for two_channel_touch_press_detector_top: a directed table, then
// calibrate/touch sequences with random content, checked against an in-bench predictor.
// Depends on tpd_pkg and the top level only.
module two_channel_touch_press_detector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpd_pkg::*;

  // Operation code 3 has no name in the package; the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int TOUCH_ITEMS = 1650;
  localparam int DRY_LIMIT   = 3000;   // cycles without any transfer before giving up
  localparam int HOLD_CYCLES = 400;    // length of the receiver hold-off
  localparam int SETTLE      = 4;      // extra wait once every release is out, used by settle()
  localparam int REPORT_CAP  = 30;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NO_RESULT, ROW_RESULT} row_check_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] stamp;
    row_check_t  chk;
    logic        sensor;
    logic [15:0] press_len;
  } script_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [15:0] cfg_data;

  two_channel_touch_press_detector_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Predictor state, at its reset values
  logic        pad_sel        = 1'b0;
  logic [15:0] last_stamp     = '0;
  logic [15:0] pad_level [2]  = '{COUNT_MAX, COUNT_MAX};
  logic [15:0] press_run [2]  = '{16'd0, 16'd0};
  logic        calibrating_now = 1'b0;
  logic [15:0] thr_now        = THRESHOLD_RESET;

  out_item_t   release_q [$];   // releases still to come out of the block
  logic [15:0] stamp = '0;      // timestamp of the last capture offered
  int          touch_items = 0;
  int          err_count = 0;
  bit          quiet = 1'b0;    // no idling on either side
  bit          hold_req = 1'b0;

  // Directed rows. Captures alternate pads, pad 1 first after reset; the stamps
  // are picked so that the periods land on the edges worked out alongside.
  script_row_t script [24] = '{
    '{OP_CAPTURE, 16'hffff, ROW_RESULT,    1'b1, 16'd0},  // pad 1, period 0xffff, at baseline
    '{OP_CAPTURE, 16'hffff, ROW_NO_RESULT, 1'b0, 16'd0},  // pad 0, period 0, press
    '{OP_CAPTURE, 16'h0000, ROW_NO_RESULT, 1'b0, 16'd0},  // pad 1, period 1 through wrap
    '{OP_UNUSED,  16'hffff, ROW_NO_RESULT, 1'b0, 16'd0},  // ignored, stamp not taken
    '{OP_CAPTURE, 16'hffff, ROW_RESULT,    1'b0, 16'd1},  // pad 0 released after one press
    '{OP_CAPTURE, 16'hfffe, ROW_RESULT,    1'b1, 16'd1},  // period wraps to 0xffff
    '{OP_FINISH,  16'h1234, ROW_NO_RESULT, 1'b0, 16'd0},  // finish while not calibrating
    '{OP_CAPTURE, 16'hffe1, ROW_PREDICT,   1'b0, 16'd0},  // exactly at lowered baseline
    '{OP_CAPTURE, 16'hffc3, ROW_PREDICT,   1'b0, 16'd0},  // one below
    '{OP_START,   16'habcd, ROW_NO_RESULT, 1'b0, 16'd0},
    '{OP_CAPTURE, 16'h00c3, ROW_PREDICT,   1'b0, 16'd0},
    '{OP_CAPTURE, 16'h02c3, ROW_PREDICT,   1'b0, 16'd0},
    '{OP_CAPTURE, 16'h0343, ROW_PREDICT,   1'b0, 16'd0},
    '{OP_CAPTURE, 16'h0643, ROW_PREDICT,   1'b0, 16'd0},  // release while calibrating
    '{OP_CAPTURE, 16'h06c3, ROW_PREDICT,   1'b0, 16'd0},  // count kept across the start
    '{OP_FINISH,  16'h0000, ROW_NO_RESULT, 1'b0, 16'd0},
    '{OP_CAPTURE, 16'h08a6, ROW_PREDICT,   1'b0, 16'd0},
    '{OP_CAPTURE, 16'h0909, ROW_PREDICT,   1'b0, 16'd0},
    '{OP_CAPTURE, 16'h0aed, ROW_PREDICT,   1'b0, 16'd0},
    '{OP_CAPTURE, 16'h0aed, ROW_PREDICT,   1'b0, 16'd0},
    '{OP_CAPTURE, 16'h0aec, ROW_PREDICT,   1'b0, 16'd0},
    '{OP_CAPTURE, 16'h0b50, ROW_PREDICT,   1'b0, 16'd0},
    '{OP_FINISH,  16'hffff, ROW_NO_RESULT, 1'b0, 16'd0},
    '{OP_UNUSED,  16'h0000, ROW_NO_RESULT, 1'b0, 16'd0}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    err_count++;
    if (err_count <= REPORT_CAP) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // One accepted item through the predictor; returns the release it causes, if any
  task automatic predict_release(input in_item_t it, output bit fired, output out_item_t rel);
    logic [15:0] period;
    fired = 1'b0;
    rel = '0;
    case (it.operation)
      OP_START: begin
        pad_sel = 1'b0;
        pad_level[0] = COUNT_MAX;
        pad_level[1] = COUNT_MAX;
        calibrating_now = 1'b1;
      end
      OP_FINISH: begin
        // margin comes off both baselines even when no calibration ran
        calibrating_now = 1'b0;
        pad_level[0] = pad_level[0] - thr_now;
        pad_level[1] = pad_level[1] - thr_now;
      end
      OP_CAPTURE: begin
        pad_sel = ~pad_sel;
        period = it.capture_time - last_stamp;
        last_stamp = it.capture_time;
        if (period < pad_level[pad_sel]) begin
          if (calibrating_now) pad_level[pad_sel] = period;
          else if (press_run[pad_sel] != COUNT_MAX) press_run[pad_sel]++;
        end else begin
          fired = 1'b1;
          rel.sensor = pad_sel;
          rel.press_length = press_run[pad_sel];
          press_run[pad_sel] = '0;
        end
      end
      default: ;
    endcase
  endtask

  // Offer one item, hold it until the transfer, then record what it should cause
  task automatic send_item(input in_item_t it, input row_check_t chk, input out_item_t lit);
    bit        fired;
    out_item_t got;
    if (!quiet) begin
      while ($urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_release(it, fired, got);
    if (it.operation == OP_CAPTURE) stamp = it.capture_time;
    if (it.operation != OP_UNUSED) touch_items++;
    case (chk)
      ROW_PREDICT: if (fired) release_q.push_back(got);
      ROW_RESULT:  release_q.push_back(lit);
      default: ;
    endcase
  endtask

  task automatic offer(input logic [1:0] op, input logic [15:0] t);
    in_item_t it;
    it.operation = op;
    it.capture_time = t;
    send_item(it, ROW_PREDICT, '0);
  endtask

  // Drain the block before touching the threshold
  task automatic settle();
    in_valid <= 1'b0;
    while (release_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr_now = v;
  endtask

  // Calibrate each pad around its own random period, then touch them: runs of presses
  // just under the expected baseline, each closed by a release just above it.
  // A sprinkle of random items breaks sequences now and then.
  task automatic touch_phase(input int n_touch, input bit squeeze);
    logic [15:0] base [2];
    logic [15:0] jit;
    logic [15:0] per;
    int          run_left [2];
    logic        ch;
    jit = 16'($urandom_range(0, 40));
    for (int i = 0; i < 2; i++) begin
      base[i] = ($urandom_range(99) < 10) ? 16'($urandom_range(0, 65535))
                                          : 16'($urandom_range(300, 4000));
      run_left[i] = $urandom_range(0, 12);
    end
    offer(OP_START, 16'($urandom_range(0, 65535)));
    repeat ($urandom_range(4, 12)) begin
      ch = ~pad_sel;
      per = 16'(base[ch] + $urandom_range(0, jit));
      offer(OP_CAPTURE, stamp + per);
    end
    offer(OP_FINISH, 16'($urandom_range(0, 65535)));
    if (squeeze) hold_req = 1'b1;
    repeat (n_touch) begin
      if ($urandom_range(99) < 8) begin
        offer(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
      end else begin
        ch = ~pad_sel;
        if (run_left[ch] > 0) begin
          per = 16'(base[ch] - thr_now - 16'd1 - $urandom_range(0, 30));
          run_left[ch]--;
        end else begin
          per = 16'(base[ch] + jit - thr_now + $urandom_range(0, 30));
          run_left[ch] = ($urandom_range(99) < 5) ? $urandom_range(50, 300)
                                                  : $urandom_range(0, 12);
        end
        offer(OP_CAPTURE, stamp + per);
      end
    end
  endtask

  // Result side: random stall, plus one long hold-off on request so that the
  // command queue and result register fill and the input backs up
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) hold_left--;
      else if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      out_stall <= (hold_left > 0) || (!quiet && $urandom_range(99) < 29);
    end
  end

  // Every result transfer is matched against the oldest outstanding release
  always @(posedge clk) begin : release_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (release_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result sensor %0d length %0d",
                                out_data.sensor, out_data.press_length));
      end else begin
        want = release_q.pop_front();
        if (out_data.sensor !== want.sensor)
          flag_mismatch($sformatf("sensor %0d, want %0d", out_data.sensor, want.sensor));
        if (out_data.press_length !== want.press_length)
          flag_mismatch($sformatf("press_length %0d, want %0d (sensor %0d)",
                                  out_data.press_length, want.press_length, want.sensor));
      end
    end
  end

  // Watchdog: any transfer on any channel resets the count
  initial begin : watchdog
    int dry_cycles;
    dry_cycles = 0;
    while (dry_cycles < DRY_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        dry_cycles = 0;
      else
        dry_cycles++;
    end
    $display("two_channel_touch_press_detector_top_tb failed");
    $finish;
  end

  initial begin : stimulus
    in_item_t  it;
    out_item_t lit;
    int        phase;
    logic [15:0] thr_pick;
    int        r;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows run on the reset threshold
    foreach (script[i]) begin
      it.operation = script[i].op;
      it.capture_time = script[i].stamp;
      lit.sensor = script[i].sensor;
      lit.press_length = script[i].press_len;
      send_item(it, script[i].chk, lit);
    end

    // Random phases, each on a fresh threshold written while the block is idle
    phase = 0;
    while (touch_items < TOUCH_ITEMS) begin
      settle();
      case (phase)
        0: thr_pick = 16'h0000;
        1: thr_pick = 16'hffff;
        2: thr_pick = THRESHOLD_RESET;
        default: begin
          r = $urandom_range(99);
          if (r < 10)      thr_pick = (r < 5) ? 16'h0000 : 16'hffff;
          else if (r < 30) thr_pick = 16'($urandom_range(0, 65535));
          else             thr_pick = 16'($urandom_range(0, 200));
        end
      endcase
      write_threshold(thr_pick);
      quiet = (phase == 5);
      touch_phase($urandom_range(30, 90), phase == 3 || phase == 11);
      quiet = 1'b0;
      phase++;
    end

    in_valid <= 1'b0;
    while (release_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("two_channel_touch_press_detector_top_tb passed");
    else
      $display("two_channel_touch_press_detector_top_tb failed");
    $finish;
  end

endmodule

### files.f
src/tpd_pkg.sv
src/tpd_front.sv
src/tpd_queue.sv
src/tpd_back.sv
src/two_channel_touch_press_detector_top.sv
tb/two_channel_touch_press_detector_top_tb.sv
